FILE: rtl/dmxr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmxr_pkg;

    localparam int NUM_PORTS        = 4;
    localparam int RING_DEPTH       = 4;
    localparam int MAX_SLOTS        = 512;
    localparam int SLOTS_PER_PACKET = MAX_SLOTS + 1;
    localparam int STORE_DEPTH      = NUM_PORTS * RING_DEPTH * SLOTS_PER_PACKET;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam int RING_W           = $clog2(RING_DEPTH);
    localparam int PIDX_W           = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    localparam logic [2:0] MODE_BYTE    = 3'd0;
    localparam logic [2:0] MODE_EOF     = 3'd1;
    localparam logic [2:0] MODE_READ    = 3'd2;
    localparam logic [2:0] MODE_RELEASE = 3'd3;
    localparam logic [2:0] MODE_TICK    = 3'd4;

    localparam logic [1:0] LS_IDLE  = 2'd0;
    localparam logic [1:0] LS_PRE   = 2'd1;
    localparam logic [1:0] LS_BREAK = 2'd2;
    localparam logic [1:0] LS_DATA  = 2'd3;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] port;
        logic [7:0] rx_byte;
        logic       break_seen;
        logic [9:0] slot_index;
    } req_t;

    typedef struct packed {
        logic        packet_available;
        logic [7:0]  slot_value;
        logic [9:0]  slot_total;
        logic [15:0] updates_per_second;
        logic        frame_committed;
        logic [1:0]  line_state;
    } rsp_t;

    typedef struct packed {
        logic        packet_available;
        logic [9:0]  slot_total;
        logic [15:0] updates_per_second;
        logic        frame_committed;
        logic [1:0]  line_state;
        logic        slot_read;
    } res_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/dmx512_multiport_receiver_top.sv
// Four-port DMX512 frame receiver with a per-port ring of captured packets.
// Request channel (req_valid/req_stall/req_data): one request per cycle
// carries a line byte, an end of frame, a slot read or release of the
// oldest packet, or the one-second tick. Response channel (rsp_valid/
// rsp_stall/rsp_data): exactly one response per request, in order.
// Configuration: cfg_we writes cfg_data into the port enable register;
// write only while no request is in flight.
// A taken request is registered in a_res_reg and then in o_data_reg.
// Throughput: one request per cycle while req_stall is low, set by the
// single port of the packet store (one byte written or read per request).
// Reset clears every port to idle, empties the rings, zeroes the frame
// counters and disables all ports; packet bytes are not cleared.
// When the receiver stalls, one response waits in the output register
// and one more in the stage behind it; after that req_stall rises and
// holds until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module dmx512_multiport_receiver_top
    import dmxr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_data,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire req_t       req_data,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_t            rsp_data
);

    logic       accept;
    mem_req_t   mem_req;
    res_t       res;
    logic [7:0] rdata;

    assign accept = req_valid && !req_stall;

    dmxr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .req      (req_data),
        .mem_req  (mem_req),
        .res      (res)
    );

    dmxr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    dmxr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .res       (res),
        .rdata     (rdata),
        .busy      (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.frame_committed |-> rsp_data.line_state == LS_IDLE)
        else $error("committed frame left port out of idle");

    a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.packet_available
        |-> rsp_data.slot_value == 8'd0 && rsp_data.slot_total == 10'd0)
        else $error("empty ring reported slot data");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !rsp_stall ##1 !rsp_stall |=> rsp_valid)
        else $error("response missing two cycles after request");

    a_mem_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.en |-> accept)
        else $error("packet store accessed without a request");

endmodule

`default_nettype wire

FILE: rtl/dmxr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dmxr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata <= mem_reg[addr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dmxr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dmxr_ctrl
    import dmxr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_data,
    input  wire logic       accept,
    input  wire req_t       req,
    output mem_req_t        mem_req,
    output res_t            res
);

    logic [1:0]        rx_state_reg   [NUM_PORTS];
    logic [9:0]        wr_pos_reg     [NUM_PORTS];
    logic [RING_W-1:0] head_reg       [NUM_PORTS];
    logic [RING_W-1:0] tail_reg       [NUM_PORTS];
    logic [15:0]       frame_cnt_reg  [NUM_PORTS];
    logic [15:0]       prev_cnt_reg   [NUM_PORTS];
    logic [15:0]       rate_reg       [NUM_PORTS];
    logic [9:0]        slot_cnt_reg   [NUM_PORTS][RING_DEPTH];
    logic [3:0]        port_enable_reg;

    logic              port_ok;
    logic [PIDX_W-1:0] pi;
    logic              enabled;
    logic [1:0]        st;
    logic [9:0]        wp;
    logic [RING_W-1:0] hd;
    logic [RING_W-1:0] tl;
    logic [RING_W-1:0] hd_inc;
    logic [RING_W-1:0] tl_inc;
    logic [10:0]       pos_inc;

    logic [1:0]        st_next;
    logic [9:0]        wp_next;
    logic [RING_W-1:0] hd_next;
    logic [RING_W-1:0] tl_next;
    logic              fc_inc;
    logic              commit;
    logic [9:0]        commit_cnt;
    logic              wr_en;
    logic [9:0]        wr_slot;
    logic [7:0]        wr_byte;
    logic              avail;
    logic [9:0]        count;
    logic              rd_en;
    logic [RING_W-1:0] mem_entry;
    logic [9:0]        mem_slot;
    logic [15:0]       updates;
    logic              upd;

    assign port_ok = ({1'b0, req.port} < 3'(NUM_PORTS));
    assign pi      = req.port[PIDX_W-1:0];
    assign enabled = port_enable_reg[req.port];
    assign st      = rx_state_reg[pi];
    assign wp      = wr_pos_reg[pi];
    assign hd      = head_reg[pi];
    assign tl      = tail_reg[pi];
    assign hd_inc  = (hd == RING_W'(RING_DEPTH - 1)) ? '0 : hd + 1'b1;
    assign tl_inc  = (tl == RING_W'(RING_DEPTH - 1)) ? '0 : tl + 1'b1;
    assign pos_inc = {1'b0, wp} + 11'd1;

    always_comb
    begin
        st_next    = st;
        wp_next    = wp;
        fc_inc     = 1'b0;
        commit     = 1'b0;
        commit_cnt = '0;
        wr_en      = 1'b0;
        wr_slot    = wp;
        wr_byte    = req.rx_byte;
        case (req.mode)
            MODE_BYTE:
            begin
                if (enabled)
                begin
                    if (req.break_seen)
                    begin
                        st_next = LS_PRE;
                    end
                    else
                    begin
                        unique case (st)
                            LS_PRE:   st_next = LS_BREAK;
                            LS_BREAK:
                            begin
                                if (req.rx_byte == 8'd0)
                                begin
                                    st_next = LS_DATA;
                                    wr_en   = 1'b1;
                                    wr_slot = '0;
                                    wr_byte = '0;
                                    wp_next = 10'd1;
                                    fc_inc  = 1'b1;
                                end
                                else
                                begin
                                    st_next = LS_IDLE;
                                end
                            end
                            LS_DATA:
                            begin
                                wr_en   = ({1'b0, wp} <= 11'(MAX_SLOTS));
                                wp_next = pos_inc[9:0];
                                if (pos_inc > 11'(MAX_SLOTS))
                                begin
                                    commit     = 1'b1;
                                    commit_cnt = 10'(MAX_SLOTS);
                                    st_next    = LS_IDLE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            MODE_EOF:
            begin
                if (enabled)
                begin
                    if (st == LS_DATA)
                    begin
                        commit     = 1'b1;
                        commit_cnt = (wp != '0) ? wp - 10'd1 : '0;
                    end
                    st_next = LS_IDLE;
                end
            end
            default: ;
        endcase
    end

    assign hd_next = commit ? hd_inc : hd;
    assign avail   = (hd_next != tl);
    assign tl_next = (req.mode == MODE_RELEASE && avail) ? tl_inc : tl;
    assign rd_en   = (req.mode == MODE_READ) && avail
                     && ({1'b0, req.slot_index} <= 11'(MAX_SLOTS));
    assign updates = (req.mode == MODE_TICK) ? frame_cnt_reg[pi] - prev_cnt_reg[pi] : rate_reg[pi];

    always_comb
    begin
        if (!avail)
        begin
            count = '0;
        end
        else if (commit && hd == tl)
        begin
            count = commit_cnt;
        end
        else
        begin
            count = slot_cnt_reg[pi][tl];
        end
    end

    assign mem_entry = wr_en ? hd : tl;
    assign mem_slot  = wr_en ? wr_slot : req.slot_index;

    always_comb
    begin
        mem_req.en    = accept && port_ok && (wr_en || rd_en);
        mem_req.we    = wr_en;
        mem_req.addr  = (ADDR_W'(pi) * ADDR_W'(RING_DEPTH) + ADDR_W'(mem_entry))
                        * ADDR_W'(SLOTS_PER_PACKET) + ADDR_W'(mem_slot);
        mem_req.wdata = wr_byte;
    end

    always_comb
    begin
        res = '0;
        if (port_ok)
        begin
            res.packet_available   = avail;
            res.slot_total         = count;
            res.updates_per_second = updates;
            res.frame_committed    = commit;
            res.line_state         = st_next;
            res.slot_read          = rd_en;
        end
    end

    assign upd = accept && port_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_enable_reg <= '0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                rx_state_reg[i]  <= LS_IDLE;
                wr_pos_reg[i]    <= '0;
                head_reg[i]      <= '0;
                tail_reg[i]      <= '0;
                frame_cnt_reg[i] <= '0;
                prev_cnt_reg[i]  <= '0;
                rate_reg[i]      <= '0;
                for (int j = 0; j < RING_DEPTH; j++)
                begin
                    slot_cnt_reg[i][j] <= '0;
                end
            end
        end
        else if (cfg_we)
        begin
            port_enable_reg <= cfg_data;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                if (port_enable_reg[i] != cfg_data[i] || !cfg_data[i])
                begin
                    rx_state_reg[i] <= LS_IDLE;
                end
            end
        end
        else if (upd)
        begin
            rx_state_reg[pi] <= st_next;
            wr_pos_reg[pi]   <= wp_next;
            head_reg[pi]     <= hd_next;
            tail_reg[pi]     <= tl_next;
            if (fc_inc)
            begin
                frame_cnt_reg[pi] <= frame_cnt_reg[pi] + 16'd1;
            end
            if (commit)
            begin
                slot_cnt_reg[pi][hd] <= commit_cnt;
            end
            if (req.mode == MODE_TICK)
            begin
                for (int i = 0; i < NUM_PORTS; i++)
                begin
                    rate_reg[i]     <= frame_cnt_reg[i] - prev_cnt_reg[i];
                    prev_cnt_reg[i] <= frame_cnt_reg[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dmxr_out.sv
`timescale 1ns / 1ps
`default_nettype none

module dmxr_out
    import dmxr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire res_t       res,
    input  wire logic [7:0] rdata,
    output logic            busy,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_t            rsp_data
);

    logic a_valid_reg;
    logic a_valid_next;
    res_t a_res_reg;
    logic o_valid_reg;
    logic o_valid_next;
    rsp_t o_data_reg;
    rsp_t o_data_next;
    logic a_adv;

    assign a_adv        = a_valid_reg && (!o_valid_reg || !rsp_stall);
    assign busy         = a_valid_reg && !a_adv;
    assign a_valid_next = accept || (a_valid_reg && !a_adv);
    assign o_valid_next = a_adv || (o_valid_reg && rsp_stall);

    always_comb
    begin
        o_data_next.packet_available   = a_res_reg.packet_available;
        o_data_next.slot_value         = a_res_reg.slot_read ? rdata : 8'd0;
        o_data_next.slot_total         = a_res_reg.slot_total;
        o_data_next.updates_per_second = a_res_reg.updates_per_second;
        o_data_next.frame_committed    = a_res_reg.frame_committed;
        o_data_next.line_state         = a_res_reg.line_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_res_reg <= res;
        end
        if (a_adv)
        begin
            o_data_reg <= o_data_next;
        end
    end

    assign rsp_valid = o_valid_reg;
    assign rsp_data  = o_data_reg;

endmodule

`default_nettype wire
